[src/ssfp_pkg.sv]
// Package for the servo status frame parser.
// Holds the parse phase type, result codes and the result beat struct.
// No dependencies.
package ssfp_pkg;

   // Parse phase of the frame parser
   typedef enum logic [2:0] {
      PH_HUNT1  = 3'd0,
      PH_HUNT2  = 3'd1,
      PH_ID     = 3'd2,
      PH_LEN    = 3'd3,
      PH_STATUS = 3'd4,
      PH_PARAM  = 3'd5,
      PH_CHECK  = 3'd6
   } phase_type;

   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam logic [7:0] MIN_LENGTH  = 8'd2;

   // Result item kinds
   localparam logic KIND_PARAM = 1'b0;
   localparam logic KIND_END   = 1'b1;

   // Frame result codes
   localparam logic [1:0] RESULT_GOOD    = 2'd0;
   localparam logic [1:0] RESULT_BAD_SUM = 2'd1;
   localparam logic [1:0] RESULT_BAD_LEN = 2'd2;

   // One result beat
   typedef struct packed {
      logic               item_kind;
      logic [7:0]         servo_id;
      logic [7:0]         status_byte;
      logic [5:0]         param_index;
      logic [7:0]         param_byte;
      logic signed [15:0] pair_word;
      logic [1:0]         frame_result;
   } rsp_type;

endpackage

[src/ssfp_rsp_fifo.sv]
// Two-entry result queue that parts the parser from the result channel.
// Depends on ssfp_pkg for the result beat struct.
module ssfp_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssfp_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssfp_pkg::rsp_type rsp_data
);

   ssfp_pkg::rsp_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              pop;

   assign pop       = rsp_valid && rsp_ready;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/servo_status_frame_parser_core.sv]
// Servo status frame parser, top level.
// Depends on ssfp_pkg and ssfp_rsp_fifo.
//
// Usage:
//   req_* carries one received bus byte per beat (req_rx_byte). The parser
//   hunts for the FF FF header, then takes id, length, status, parameter
//   bytes and checksum. Each parameter byte gives one rsp beat with its
//   index, raw value and (from the second byte on) a sign-magnitude word of
//   the previous and this byte. The checksum byte, or a bad length byte,
//   gives an end-of-frame beat with the frame result.
//   Each result goes into the two-entry result queue when its byte is accepted.
//   Throughput: one byte per cycle while the queue is not full; the phase
//   update and 8-bit checksum add sit between the input port and the queue.
//   Reset (synchronous, active high) returns the parser to header hunting
//   and empties the result queue.
//   When the receiver stalls, the queue holds up to two results; req_ready
//   drops only while the queue is full.
module servo_status_frame_parser_core #(
   parameter int MAX_FRAME_BYTES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_item_kind,
   output logic [7:0]         rsp_servo_id,
   output logic [7:0]         rsp_status_byte,
   output logic [5:0]         rsp_param_index,
   output logic [7:0]         rsp_param_byte,
   output logic signed [15:0] rsp_pair_word,
   output logic [1:0]         rsp_frame_result
);

   localparam logic [8:0] MaxBytes = 9'(MAX_FRAME_BYTES);

   ssfp_pkg::phase_type phase_ff;
   ssfp_pkg::phase_type phase_in;
   logic [7:0]          frame_id_ff;
   logic [7:0]          frame_id_in;
   logic [7:0]          param_total_ff;
   logic [7:0]          param_total_in;
   logic [7:0]          frame_status_ff;
   logic [7:0]          frame_status_in;
   logic [7:0]          param_count_ff;
   logic [7:0]          param_count_in;
   logic [7:0]          sum_ff;
   logic [7:0]          sum_in;
   logic [7:0]          prev_ff;
   logic [7:0]          prev_in;

   logic                accept;
   logic                fifo_full;
   logic                out_push;
   ssfp_pkg::rsp_type   out_data;
   ssfp_pkg::rsp_type   rsp_data;
   logic                len_bad;
   logic [15:0]         raw_word;
   logic [15:0]         pair_word;

   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;

   // Length check and sign-magnitude conversion
   assign len_bad  = (req_rx_byte < ssfp_pkg::MIN_LENGTH) ||
                     (({1'b0, req_rx_byte} + 9'd2) >= MaxBytes);
   assign raw_word = {req_rx_byte, prev_ff};
   assign pair_word = raw_word[15] ? (16'd0 - {1'b0, raw_word[14:0]}) : raw_word;

   // Next phase and frame registers
   always_comb begin
      phase_in        = phase_ff;
      frame_id_in     = frame_id_ff;
      param_total_in  = param_total_ff;
      frame_status_in = frame_status_ff;
      param_count_in  = param_count_ff;
      sum_in          = sum_ff;
      prev_in         = prev_ff;
      unique case (phase_ff)
         ssfp_pkg::PH_HUNT1: begin
            phase_in = (req_rx_byte == ssfp_pkg::HEADER_BYTE) ?
                       ssfp_pkg::PH_HUNT2 : ssfp_pkg::PH_HUNT1;
         end
         ssfp_pkg::PH_HUNT2: begin
            phase_in = (req_rx_byte == ssfp_pkg::HEADER_BYTE) ?
                       ssfp_pkg::PH_ID : ssfp_pkg::PH_HUNT1;
         end
         ssfp_pkg::PH_ID: begin
            frame_id_in     = req_rx_byte;
            frame_status_in = 8'd0;
            param_count_in  = 8'd0;
            prev_in         = 8'd0;
            sum_in          = req_rx_byte;
            phase_in        = ssfp_pkg::PH_LEN;
         end
         ssfp_pkg::PH_LEN: begin
            if (len_bad) begin
               frame_status_in = 8'd0;
               phase_in        = ssfp_pkg::PH_HUNT1;
            end else begin
               param_total_in = req_rx_byte - ssfp_pkg::MIN_LENGTH;
               sum_in         = sum_ff + req_rx_byte;
               phase_in       = ssfp_pkg::PH_STATUS;
            end
         end
         ssfp_pkg::PH_STATUS: begin
            frame_status_in = req_rx_byte;
            sum_in          = sum_ff + req_rx_byte;
            phase_in        = (param_total_ff == 8'd0) ?
                              ssfp_pkg::PH_CHECK : ssfp_pkg::PH_PARAM;
         end
         ssfp_pkg::PH_PARAM: begin
            sum_in         = sum_ff + req_rx_byte;
            prev_in        = req_rx_byte;
            param_count_in = param_count_ff + 8'd1;
            // last parameter once the updated count reaches the total
            if (param_count_in >= param_total_ff) begin
               phase_in = ssfp_pkg::PH_CHECK;
            end
         end
         ssfp_pkg::PH_CHECK: begin
            phase_in = ssfp_pkg::PH_HUNT1;
         end
         default: begin
            phase_in = ssfp_pkg::PH_HUNT1;
         end
      endcase
   end

   // Result beat for the current byte
   always_comb begin
      out_push              = 1'b0;
      out_data.item_kind    = ssfp_pkg::KIND_END;
      out_data.servo_id     = frame_id_ff;
      out_data.status_byte  = frame_status_ff;
      out_data.param_index  = 6'd0;
      out_data.param_byte   = 8'd0;
      out_data.pair_word    = 16'sd0;
      out_data.frame_result = ssfp_pkg::RESULT_GOOD;
      unique case (phase_ff)
         ssfp_pkg::PH_LEN: begin
            out_push              = accept && len_bad;
            out_data.status_byte  = 8'd0;
            out_data.frame_result = ssfp_pkg::RESULT_BAD_LEN;
         end
         ssfp_pkg::PH_PARAM: begin
            out_push             = accept;
            out_data.item_kind   = ssfp_pkg::KIND_PARAM;
            out_data.param_index = param_count_ff[5:0];
            out_data.param_byte  = req_rx_byte;
            out_data.pair_word   = (param_count_ff != 8'd0) ? $signed(pair_word) : 16'sd0;
         end
         ssfp_pkg::PH_CHECK: begin
            out_push              = accept;
            out_data.frame_result = (req_rx_byte == ~sum_ff) ?
                                    ssfp_pkg::RESULT_GOOD : ssfp_pkg::RESULT_BAD_SUM;
         end
         default: begin
            out_push = 1'b0;
         end
      endcase
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ssfp_pkg::PH_HUNT1;
         frame_id_ff     <= 8'd0;
         param_total_ff  <= 8'd0;
         frame_status_ff <= 8'd0;
         param_count_ff  <= 8'd0;
         sum_ff          <= 8'd0;
         prev_ff         <= 8'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         frame_id_ff     <= frame_id_in;
         param_total_ff  <= param_total_in;
         frame_status_ff <= frame_status_in;
         param_count_ff  <= param_count_in;
         sum_ff          <= sum_in;
         prev_ff         <= prev_in;
      end
   end

   ssfp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (fifo_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_item_kind    = rsp_data.item_kind;
   assign rsp_servo_id     = rsp_data.servo_id;
   assign rsp_status_byte  = rsp_data.status_byte;
   assign rsp_param_index  = rsp_data.param_index;
   assign rsp_param_byte   = rsp_data.param_byte;
   assign rsp_pair_word    = rsp_data.pair_word;
   assign rsp_frame_result = rsp_data.frame_result;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for servo_status_frame_parser_core: bytes in, parameter and end-of-frame beats out.
// Depends on ssfp_pkg and the core RTL; tracks the parser in-bench and checks each rsp beat.
module tb;

   localparam int FRAME_LIMIT = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 4;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_item_kind;
   logic [7:0]         rsp_servo_id;
   logic [7:0]         rsp_status_byte;
   logic [5:0]         rsp_param_index;
   logic [7:0]         rsp_param_byte;
   logic signed [15:0] rsp_pair_word;
   logic [1:0]         rsp_frame_result;

   servo_status_frame_parser_core #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_servo_id     (rsp_servo_id),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_param_index  (rsp_param_index),
      .rsp_param_byte   (rsp_param_byte),
      .rsp_pair_word    (rsp_pair_word),
      .rsp_frame_result (rsp_frame_result)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Parser tracking state
   ssfp_pkg::phase_type track_phase;
   logic [7:0]  track_id;
   logic [7:0]  track_total;
   logic [7:0]  track_status;
   logic [7:0]  track_count;
   logic [7:0]  track_sum;
   logic [7:0]  track_prev;

   ssfp_pkg::rsp_type frame_beats_due[$];
   logic [7:0]  param_list[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   // Advance the tracked parser by one received byte; queue any beat it yields
   function automatic void track_frame_byte(input logic [7:0] b);
      ssfp_pkg::rsp_type beat;
      logic [15:0] w;
      beat = '0;
      unique case (track_phase)
         ssfp_pkg::PH_HUNT2:
            track_phase = (b == ssfp_pkg::HEADER_BYTE) ?
                          ssfp_pkg::PH_ID : ssfp_pkg::PH_HUNT1;
         ssfp_pkg::PH_ID: begin
            track_id     = b;
            track_status = 8'd0;
            track_count  = 8'd0;
            track_prev   = 8'd0;
            track_sum    = b;
            track_phase  = ssfp_pkg::PH_LEN;
         end
         ssfp_pkg::PH_LEN: begin
            if (b < ssfp_pkg::MIN_LENGTH || int'(b) + 2 >= FRAME_LIMIT) begin
               track_status      = 8'd0;
               beat.item_kind    = ssfp_pkg::KIND_END;
               beat.servo_id     = track_id;
               beat.frame_result = ssfp_pkg::RESULT_BAD_LEN;
               frame_beats_due.push_back(beat);
               track_phase = ssfp_pkg::PH_HUNT1;
            end else begin
               track_total = b - ssfp_pkg::MIN_LENGTH;
               track_sum   = track_sum + b;
               track_phase = ssfp_pkg::PH_STATUS;
            end
         end
         ssfp_pkg::PH_STATUS: begin
            track_status = b;
            track_sum    = track_sum + b;
            track_phase  = (track_total == 8'd0) ?
                           ssfp_pkg::PH_CHECK : ssfp_pkg::PH_PARAM;
         end
         ssfp_pkg::PH_PARAM: begin
            // sign-magnitude word, previous byte low, this byte high
            w = {b, track_prev};
            if (track_count == 8'd0)
               beat.pair_word = '0;
            else if (w[15])
               beat.pair_word = 16'd0 - {1'b0, w[14:0]};
            else
               beat.pair_word = w;
            beat.item_kind    = ssfp_pkg::KIND_PARAM;
            beat.servo_id     = track_id;
            beat.status_byte  = track_status;
            beat.param_index  = track_count[5:0];
            beat.param_byte   = b;
            beat.frame_result = ssfp_pkg::RESULT_GOOD;
            frame_beats_due.push_back(beat);
            track_sum   = track_sum + b;
            track_prev  = b;
            track_count = track_count + 8'd1;
            if (track_count >= track_total)
               track_phase = ssfp_pkg::PH_CHECK;
         end
         ssfp_pkg::PH_CHECK: begin
            beat.item_kind    = ssfp_pkg::KIND_END;
            beat.servo_id     = track_id;
            beat.status_byte  = track_status;
            beat.frame_result = (b == ~track_sum) ?
                                ssfp_pkg::RESULT_GOOD : ssfp_pkg::RESULT_BAD_SUM;
            frame_beats_due.push_back(beat);
            track_phase = ssfp_pkg::PH_HUNT1;
         end
         default:
            track_phase = (b == ssfp_pkg::HEADER_BYTE) ?
                          ssfp_pkg::PH_HUNT2 : ssfp_pkg::PH_HUNT1;
      endcase
   endfunction

   // Present one byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      track_frame_byte(b);
   endtask

   // Full frame around param_list; corrupt flips checksum bits
   task automatic send_frame(input logic [7:0] id, input logic [7:0] status,
                             input logic corrupt);
      logic [7:0] len;
      logic [7:0] sum;
      len = 8'(param_list.size()) + ssfp_pkg::MIN_LENGTH;
      sum = id + len + status;
      foreach (param_list[i]) sum = sum + param_list[i];
      sum = ~sum;
      if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(ssfp_pkg::HEADER_BYTE);
      send_byte(ssfp_pkg::HEADER_BYTE);
      send_byte(id);
      send_byte(len);
      send_byte(status);
      foreach (param_list[i]) send_byte(param_list[i]);
      send_byte(sum);
   endtask

   task automatic send_bad_length(input logic [7:0] id, input logic [7:0] len);
      send_byte(ssfp_pkg::HEADER_BYTE);
      send_byte(ssfp_pkg::HEADER_BYTE);
      send_byte(id);
      send_byte(len);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Broken header, then a frame whose id is itself a header byte, no params
   task automatic test_header_hunting();
      send_byte(ssfp_pkg::HEADER_BYTE);
      send_byte(8'h00);
      param_list = {};
      send_frame(ssfp_pkg::HEADER_BYTE, 8'h00, 1'b0);
   endtask

   // Length byte below minimum and just past the buffer
   task automatic test_bad_lengths();
      send_bad_length(8'h00, 8'd0);
      send_bad_length(8'hA5, 8'(FRAME_LIMIT - 2));
   endtask

   // Pair words across sign and magnitude extremes, then a bad checksum
   task automatic test_param_words();
      param_list = {8'h00, 8'h80, 8'hFF, 8'hFF, 8'h01};
      send_frame(8'h5A, 8'hFF, 1'b0);
      param_list = {};
      send_frame(8'h01, 8'h00, 1'b1);
   endtask

   // Mostly well-formed frames, some bad lengths, broken headers and noise
   task automatic test_random_traffic(input int target, input int send_pct,
                                      input int recv_pct);
      int sent;
      int pick;
      int n;
      int k;
      logic [7:0] v;
      sent = 0;
      set_idling(send_pct, recv_pct);
      while (sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, FRAME_LIMIT - 5)
                                            : $urandom_range(0, 8);
            param_list = {};
            for (k = 0; k < n; k++) begin
               case ($urandom_range(0, 7))
                  0: v = 8'h00;
                  1: v = 8'hFF;
                  2: v = 8'h80;
                  3: v = 8'h7F;
                  default: v = 8'($urandom_range(0, 255));
               endcase
               param_list.push_back(v);
            end
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       $urandom_range(0, 9) == 0);
            sent += n + 6;
         end else if (pick < 80) begin
            v = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                            : 8'($urandom_range(FRAME_LIMIT - 2, 255));
            send_bad_length(8'($urandom_range(0, 255)), v);
            sent += 4;
         end else if (pick < 90) begin
            // header cut short, or a frame start that stops mid-way
            send_byte(ssfp_pkg::HEADER_BYTE);
            send_byte(8'($urandom_range(0, 255)));
            sent += 2;
            if ($urandom_range(0, 1) == 0) begin
               send_byte(8'($urandom_range(0, 255)));
               send_byte(8'($urandom_range(2, FRAME_LIMIT - 3)));
               n = $urandom_range(0, 3);
               for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
               sent += n + 2;
            end
         end else begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
            sent += n;
         end
      end
   endtask

   // Receiver stall
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[servo_status_frame_parser_core] ERROR");
         $finish;
      end
   end

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Check each accepted rsp beat against the oldest one due
   always @(posedge clock) begin
      ssfp_pkg::rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_beats_due.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none actual kind %0d id %0h",
                     $time, rsp_item_kind, rsp_servo_id);
            error_count++;
         end else begin
            due = frame_beats_due.pop_front();
            compare_field("item_kind", due.item_kind, rsp_item_kind);
            compare_field("servo_id", due.servo_id, rsp_servo_id);
            compare_field("status_byte", due.status_byte, rsp_status_byte);
            compare_field("param_index", due.param_index, rsp_param_index);
            compare_field("param_byte", due.param_byte, rsp_param_byte);
            compare_field("pair_word", int'(due.pair_word), int'(rsp_pair_word));
            compare_field("frame_result", due.frame_result, rsp_frame_result);
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      rsp_ready   = 1'b0;
      track_phase  = ssfp_pkg::PH_HUNT1;
      track_id     = 8'd0;
      track_total  = 8'd0;
      track_status = 8'd0;
      track_count  = 8'd0;
      track_sum    = 8'd0;
      track_prev   = 8'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_header_hunting();
      test_bad_lengths();
      test_param_words();
      test_random_traffic(375, 0, 0);
      test_random_traffic(375, 49, 0);
      test_random_traffic(375, 0, 49);
      test_random_traffic(375, 16, 16);

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (frame_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[servo_status_frame_parser_core] OK");
      else
         $display("[servo_status_frame_parser_core] ERROR");
      $finish;
   end

endmodule
